/* rtl/core/cld_pkg.sv */
// Package for the content-length frame deframer core.
// Holds field widths, result and error codes, parser phase codes and the marker text.
// No dependencies.
package cld_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HDR_LEN_W  = 17;
    localparam int unsigned BODY_LEN_W = 25;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CODE_W     = 2;
    localparam int unsigned TERM_W     = 2;
    localparam int unsigned MARK_W     = 4;
    localparam int unsigned PHASE_W    = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = BODY_LEN_W;

    localparam logic [HDR_LEN_W-1:0]  MAX_HDR_RESET  = 17'd65536;
    localparam logic [BODY_LEN_W-1:0] MAX_BODY_RESET = 25'd16777216;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HDR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY = 1'd1;

    localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    localparam logic [CODE_W-1:0] ERR_HDR_LONG  = 2'd0;
    localparam logic [CODE_W-1:0] ERR_NO_FIELD  = 2'd1;
    localparam logic [CODE_W-1:0] ERR_NOT_DEC   = 2'd2;
    localparam logic [CODE_W-1:0] ERR_TOO_LARGE = 2'd3;

    localparam logic [PHASE_W-1:0] PH_SEARCH = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SPACE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE   = 2'd3;

    localparam logic [BYTE_W-1:0] CR_BYTE = 8'h0D;
    localparam logic [BYTE_W-1:0] LF_BYTE = 8'h0A;
    localparam logic [MARK_W-1:0] MARK_LEN = 4'd15;

    // lower-case "content-length:"
    function automatic logic [BYTE_W-1:0] marker_char(input logic [MARK_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h74;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h2D;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h65;
            4'd10:   c = 8'h6E;
            4'd11:   c = 8'h67;
            4'd12:   c = 8'h74;
            4'd13:   c = 8'h68;
            4'd14:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/content_length_frame_deframer_core.sv */
// Content-length frame deframer core: header parse, length check, body pass-through.
// Depends on cld_pkg.
//
//   channel   signals                                            direction
//   in        in_valid, in_ready, in_byte                        word in
//   out       out_valid, out_ready, result_kind, body_byte,
//             last_of_frame, error_code                          word out
//   cfg       cfg_we, cfg_index, cfg_data                        register write
//
// One word per cycle while in_ready is high; header parse state updates at the input handshake and the
// result is registered at that same edge, so it is on the outputs the next cycle.
// in_ready is high while the output register is empty or being drained.
// Reset clears the header state; limit registers reset to 65536 and 16777216.
module content_length_frame_deframer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cld_pkg::BYTE_W-1:0]         in_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cld_pkg::KIND_W-1:0]         result_kind,
    output logic [cld_pkg::BYTE_W-1:0]         body_byte,
    output logic                               last_of_frame,
    output logic [cld_pkg::CODE_W-1:0]         error_code,
    input  logic                               cfg_we,
    input  logic [cld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cld_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cld_pkg::*;

    logic [HDR_LEN_W-1:0]  max_hdr_reg;
    logic [BODY_LEN_W-1:0] max_body_reg;

    logic                  in_body_reg,     in_body_next;
    logic [TERM_W-1:0]     term_reg,        term_next;
    logic [MARK_W-1:0]     mark_reg,        mark_next;
    logic [PHASE_W-1:0]    phase_reg,       phase_next;
    logic                  seen_digit_reg,  seen_digit_next;
    logic                  overflow_reg,    overflow_next;
    logic [BODY_LEN_W-1:0] len_reg,         len_next;
    logic [HDR_LEN_W-1:0]  hdr_count_reg,   hdr_count_next;
    logic [BODY_LEN_W-1:0] remaining_reg,   remaining_next;

    logic                  out_valid_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  last_reg;
    logic [CODE_W-1:0]     code_reg;

    logic                  in_fire;
    logic                  res_valid;
    logic [KIND_W-1:0]     res_kind;
    logic [BYTE_W-1:0]     res_byte;
    logic                  res_last;
    logic [CODE_W-1:0]     res_code;
    logic                  fresh;
    logic                  start_body;

    logic [BYTE_W-1:0]     lower;
    logic                  is_digit;
    logic                  is_space;
    logic [3:0]            digit_val;
    logic                  completes;
    logic [TERM_W:0]       new_match;
    logic [HDR_LEN_W:0]    content;
    logic [BODY_LEN_W+3:0] prod;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign lower     = (in_byte inside {[8'h41:8'h5A]}) ? in_byte + 8'd32 : in_byte;
    assign is_digit  = in_byte inside {[8'h30:8'h39]};
    assign is_space  = (in_byte == 8'h20) || (in_byte inside {[8'h09:8'h0D]});
    assign digit_val = in_byte[3:0];
    assign prod      = {1'b0, len_reg, 3'b000} + {3'b000, len_reg, 1'b0}
                     + {25'd0, digit_val};

    // new_match reaches 4 on the completing LF
    always_comb
    begin
        completes = (term_reg == 2'd3) && (in_byte == LF_BYTE);
        if (((term_reg == 2'd0) || (term_reg == 2'd2)) && (in_byte == CR_BYTE))
        begin
            new_match = {1'b0, term_reg} + 3'd1;
        end
        else if (((term_reg == 2'd1) || (term_reg == 2'd3)) && (in_byte == LF_BYTE))
        begin
            new_match = {1'b0, term_reg} + 3'd1;
        end
        else
        begin
            new_match = (in_byte == CR_BYTE) ? 3'd1 : 3'd0;
        end
        content = {1'b0, hdr_count_reg} + {16'd0, term_reg} + 18'd1 - {15'd0, new_match};
    end

    always_comb
    begin
        in_body_next    = in_body_reg;
        term_next       = term_reg;
        mark_next       = mark_reg;
        phase_next      = phase_reg;
        seen_digit_next = seen_digit_reg;
        overflow_next   = overflow_reg;
        len_next        = len_reg;
        hdr_count_next  = hdr_count_reg;
        remaining_next  = remaining_reg;
        res_valid       = 1'b0;
        res_kind        = KIND_BODY;
        res_byte        = '0;
        res_last        = 1'b0;
        res_code        = ERR_HDR_LONG;
        fresh           = 1'b0;
        start_body      = 1'b0;

        if (in_fire)
        begin
            if (in_body_reg)
            begin
                res_valid = 1'b1;
                res_byte  = in_byte;
                if (remaining_reg <= 25'd1)
                begin
                    res_last = 1'b1;
                    fresh    = 1'b1;
                end
                else
                begin
                    remaining_next = remaining_reg - 25'd1;
                end
            end
            else if (content > {1'b0, max_hdr_reg})
            begin
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_code  = ERR_HDR_LONG;
                fresh     = 1'b1;
            end
            else
            begin
                hdr_count_next = content[HDR_LEN_W-1:0];
                if (!completes)
                begin
                    term_next = new_match[TERM_W-1:0];
                    case (phase_reg)
                        PH_SEARCH:
                        begin
                            if (lower == marker_char(mark_reg))
                            begin
                                mark_next = mark_reg + 4'd1;
                                if (mark_reg == MARK_LEN - 4'd1)
                                begin
                                    phase_next = PH_SPACE;
                                end
                            end
                            else
                            begin
                                mark_next = (lower == marker_char(4'd0)) ? 4'd1 : 4'd0;
                            end
                        end
                        PH_SPACE, PH_DIGITS:
                        begin
                            if (is_digit)
                            begin
                                phase_next      = PH_DIGITS;
                                seen_digit_next = 1'b1;
                                if (!overflow_reg)
                                begin
                                    if (prod > {4'd0, max_body_reg})
                                    begin
                                        overflow_next = 1'b1;
                                    end
                                    else
                                    begin
                                        len_next = prod[BODY_LEN_W-1:0];
                                    end
                                end
                            end
                            else if (!(is_space && (phase_reg == PH_SPACE)))
                            begin
                                phase_next = PH_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (phase_reg == PH_SEARCH)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_NO_FIELD;
                    fresh     = 1'b1;
                end
                else if (!seen_digit_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_NOT_DEC;
                    fresh     = 1'b1;
                end
                else if (overflow_reg)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_ERROR;
                    res_code  = ERR_TOO_LARGE;
                    fresh     = 1'b1;
                end
                else if (len_reg == '0)
                begin
                    res_valid = 1'b1;
                    res_kind  = KIND_EMPTY;
                    fresh     = 1'b1;
                end
                else
                begin
                    fresh      = 1'b1;
                    start_body = 1'b1;
                end
            end
        end

        if (fresh)
        begin
            in_body_next    = start_body;
            term_next       = '0;
            mark_next       = '0;
            phase_next      = PH_SEARCH;
            seen_digit_next = 1'b0;
            overflow_next   = 1'b0;
            len_next        = '0;
            hdr_count_next  = '0;
            remaining_next  = start_body ? len_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hdr_reg    <= MAX_HDR_RESET;
            max_body_reg   <= MAX_BODY_RESET;
            in_body_reg    <= 1'b0;
            term_reg       <= '0;
            mark_reg       <= '0;
            phase_reg      <= PH_SEARCH;
            seen_digit_reg <= 1'b0;
            overflow_reg   <= 1'b0;
            len_reg        <= '0;
            hdr_count_reg  <= '0;
            remaining_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MAX_HDR)
                begin
                    max_hdr_reg <= cfg_data[HDR_LEN_W-1:0];
                end
                else
                begin
                    max_body_reg <= cfg_data;
                end
            end
            in_body_reg    <= in_body_next;
            term_reg       <= term_next;
            mark_reg       <= mark_next;
            phase_reg      <= phase_next;
            seen_digit_reg <= seen_digit_next;
            overflow_reg   <= overflow_next;
            len_reg        <= len_next;
            hdr_count_reg  <= hdr_count_next;
            remaining_reg  <= remaining_next;
            if (in_fire && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            kind_reg <= res_kind;
            byte_reg <= res_byte;
            last_reg <= res_last;
            code_reg <= res_code;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign body_byte     = byte_reg;
    assign last_of_frame = last_reg;
    assign error_code    = code_reg;

    a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> (term_reg == '0) && (phase_reg == PH_SEARCH) && (hdr_count_reg == '0))
        else $error("header state not cleared in body phase");

    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> (remaining_reg != '0))
        else $error("body phase with zero bytes remaining");

    a_nonbody_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_BODY)) |-> (!last_reg && (byte_reg == '0)))
        else $error("body fields set on non-body result");

    a_error_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid && (res_kind == KIND_ERROR))
        |=> (!in_body_reg && (hdr_count_reg == '0) && (mark_reg == '0)))
        else $error("no fresh header after protocol error");

    a_digits_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DIGITS) |-> seen_digit_reg)
        else $error("digit phase without a digit");

endmodule
